@@ rtl/bbc_pkg.sv @@
// Package: item types, status codes and bracket decoding for the bracket checker.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned StackDepthDefault = 128;

  // Verdict and error codes carried in the status field.
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_CLOSE_NO_OPEN = 3'd1,
    ST_MISMATCH      = 3'd2,
    ST_UNCLOSED      = 3'd3,
    ST_OVERFLOW      = 3'd4
  } status_e;

  // Bracket kind as held on the stack.
  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_e;

  localparam logic [7:0] ChOpenParen   = 8'h28;  // (
  localparam logic [7:0] ChCloseParen  = 8'h29;  // )
  localparam logic [7:0] ChOpenSquare  = 8'h5B;  // [
  localparam logic [7:0] ChCloseSquare = 8'h5D;  // ]
  localparam logic [7:0] ChOpenCurly   = 8'h7B;  // {
  localparam logic [7:0] ChCloseCurly  = 8'h7D;  // }

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       verdict_final;
    logic [2:0] status;
    logic [7:0] nesting_depth;
  } out_item_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.is_open  = 1'b0;
    r.is_close = 1'b0;
    r.kind     = KIND_PAREN;
    case (c)
      ChOpenParen: begin
        r.is_open = 1'b1;
        r.kind    = KIND_PAREN;
      end
      ChOpenSquare: begin
        r.is_open = 1'b1;
        r.kind    = KIND_SQUARE;
      end
      ChOpenCurly: begin
        r.is_open = 1'b1;
        r.kind    = KIND_CURLY;
      end
      ChCloseParen: begin
        r.is_close = 1'b1;
        r.kind     = KIND_PAREN;
      end
      ChCloseSquare: begin
        r.is_close = 1'b1;
        r.kind     = KIND_SQUARE;
      end
      ChCloseCurly: begin
        r.is_close = 1'b1;
        r.kind     = KIND_CURLY;
      end
      default: begin
        r.is_open  = 1'b0;
        r.is_close = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bbc_kind_ram.sv @@
// Stack body memory: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps

module bbc_kind_ram #(
  parameter int unsigned Depth = bbc_pkg::StackDepthDefault,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  bbc_pkg::kind_e   wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output bbc_pkg::kind_e   rdata_o
);

  bbc_pkg::kind_e mem_q [Depth];
  bbc_pkg::kind_e rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Forward the word being written when the read hits the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bracket_balance_checker.sv @@
// Top level of the bracket checker: stack control, verdict logic and output register.
`timescale 1ns / 1ps

// Channel  Direction  Payload                 Handshake
// in       input      bbc_pkg::in_item_t      in_valid_i / in_ready_o
// out      output     bbc_pkg::out_item_t     out_valid_o / out_ready_i
//
// Throughput is one item per cycle unless the output stalls; every item yields one
// result item, registered in the cycle after it is accepted. The rate is set by the
// single push or pop per item on the stack memory: the top entry lives in a register
// and the entry beneath it is prefetched from the memory each cycle, so a pop never
// waits for a read. Reset clears the depth count, the sticky error and the output
// valid; the memory contents are not cleared. A stalled output holds its item; the
// input is still taken in the cycle the waiting result leaves.

module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bbc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbc_pkg::out_item_t out_data_o
);

  // Count holds 0..STACK_DEPTH; the memory holds every entry but the top one.
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [CntW-1:0]     cnt_q, cnt_d, cnt_step;
  bbc_pkg::status_e    err_q, err_d, err_step;
  bbc_pkg::kind_e      top_q, top_d;
  bbc_pkg::kind_e      second;
  bbc_pkg::char_class_t cls;

  logic                out_valid_q;
  bbc_pkg::out_item_t  out_data_q, out_data_d;

  logic                in_fire;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [CntW-1:0]     rd_cnt;
  bbc_pkg::status_e    status;

  // Accept while the output register is empty or draining this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cls = bbc_pkg::classify(in_data_i.char_code);

  always_comb begin
    cnt_step = cnt_q;
    err_step = err_q;
    top_d    = top_q;
    ram_we   = 1'b0;
    // Push writes the old top just below the new one.
    ram_waddr = AddrW'(cnt_q - CntW'(1));

    if (in_fire && (err_q == bbc_pkg::ST_OK)) begin
      if (cls.is_open) begin
        if (cnt_q == CntW'(STACK_DEPTH)) begin
          err_step = bbc_pkg::ST_OVERFLOW;
        end else begin
          ram_we   = (cnt_q != '0);
          top_d    = cls.kind;
          cnt_step = cnt_q + CntW'(1);
        end
      end else if (cls.is_close) begin
        if (cnt_q == '0) begin
          err_step = bbc_pkg::ST_CLOSE_NO_OPEN;
        end else if (top_q != cls.kind) begin
          err_step = bbc_pkg::ST_MISMATCH;
        end else begin
          // Pop: the prefetched entry below becomes the top.
          top_d    = second;
          cnt_step = cnt_q - CntW'(1);
        end
      end
    end

    // Verdict from the state after this character, before end-of-string clearing.
    status = err_step;
    if (in_data_i.is_last && (err_step == bbc_pkg::ST_OK) && (cnt_step != '0)) begin
      status = bbc_pkg::ST_UNCLOSED;
    end

    out_data_d.verdict_final = in_data_i.is_last;
    out_data_d.status        = status;
    out_data_d.nesting_depth = (32'(cnt_step) > 32'd255) ? 8'hFF : 8'(cnt_step);

    // Drop stack and error at the end of a string.
    cnt_d = cnt_step;
    err_d = err_step;
    if (in_fire && in_data_i.is_last) begin
      cnt_d = '0;
      err_d = bbc_pkg::ST_OK;
    end

    // Prefetch the entry that will sit below the top next cycle.
    rd_cnt    = cnt_d - CntW'(2);
    ram_raddr = AddrW'(rd_cnt);
  end

  bbc_kind_ram #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (top_q),
    .raddr_i (ram_raddr),
    .rdata_o (second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= bbc_pkg::ST_OK;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // Top-of-stack is payload: only read while the count is non-zero.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // End of string leaves an empty stack and no error.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.is_last |=> (cnt_q == '0) && (err_q == bbc_pkg::ST_OK))
    else $error("stack or error not cleared after last item");

  // Depth never passes the stack size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // Once an error is latched, the stack is frozen until the string ends.
  a_err_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != bbc_pkg::ST_OK) && !(in_fire && in_data_i.is_last) |=> $stable(cnt_q))
    else $error("stack moved after sticky error");

  // A held result blocks intake.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");
`endif

endmodule
